### design/pcgfy_pkg.sv
// Shared types, constants and the helper function of the PCG32 shuffle table.
`default_nettype none
package pcgfy_pkg;

   // Default sizes of the entry table.
   localparam int unsigned MAX_ENTRIES_DEF = 1024;
   localparam int unsigned ENTRY_WIDTH_DEF = 32;

   // Fixed transaction field widths.
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned POS_W     = 10;
   localparam int unsigned COUNT_W   = 11;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned SEED_W    = 64;
   localparam int unsigned STREAM_W  = 63;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 64;
   localparam int unsigned DRAW_W    = 64;

   typedef logic [MODE_W-1:0]    mode_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [1:0]           rsp_sel_type;

   localparam mode_type MODE_CLEAR   = 2'd0;
   localparam mode_type MODE_APPEND  = 2'd1;
   localparam mode_type MODE_SHUFFLE = 2'd2;
   localparam mode_type MODE_READ    = 2'd3;

   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_FULL   = 2'd1;
   localparam status_type STATUS_BEYOND = 2'd2;

   localparam csr_idx_type CSR_SEED   = 1'b0;
   localparam csr_idx_type CSR_STREAM = 1'b1;

   localparam rsp_sel_type RSP_DIRECT  = 2'd0;
   localparam rsp_sel_type RSP_READ    = 2'd1;
   localparam rsp_sel_type RSP_SHUFFLE = 2'd2;

   // PCG multiplier 6364136223846793005, split into halves.
   localparam logic [31:0] PCG_MULT_LO = 32'h4C957F2D;
   localparam logic [31:0] PCG_MULT_HI = 32'h5851F42D;

   // Multiplier phases of one generator step.
   localparam logic [1:0] MUL_LOLO = 2'd0;
   localparam logic [1:0] MUL_LOHI = 2'd1;
   localparam logic [1:0] MUL_HILO = 2'd2;
   localparam logic [1:0] MUL_SUM  = 2'd3;

   // XSH-RR output permutation of the old generator state.
   function automatic logic [31:0] pcg_output(input logic [63:0] s);
      logic [63:0] x;
      logic [31:0] m;
      logic [4:0]  r;
      logic [4:0]  rl;
      x  = (s >> 18) ^ s;
      m  = x[58:27];
      r  = s[63:59];
      rl = 5'd0 - r;
      return (m >> r) | (m << rl);
   endfunction

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        count_clear;
      logic        append;
      logic        read_pos;
      logic        shuffle_start;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
      logic        mul_en;
      logic [1:0]  mul_phase;
      logic        cap_hi;
      logic        cap_lo;
      logic        div_limit;
      logic        div_draw;
      logic        limit_load;
      logic        pick_load;
      logic        rd_last;
      logic        rd_pick;
      logic        tmp_load;
      logic        wr_last;
      logic        wr_pick;
      logic        top_dec;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_free;
      logic short_top;
      logic draw_low;
      logic div_done;
   } sts_type;

endpackage
`default_nettype wire

### design/pcgfy_if.sv
// Valid/ready channel interfaces for requests, responses and register writes.
`default_nettype none
interface pcgfy_req_if;
   logic                           valid;
   logic                           ready;
   pcgfy_pkg::mode_type            mode;
   logic [pcgfy_pkg::VALUE_W-1:0]  entry_value;
   logic [pcgfy_pkg::POS_W-1:0]    read_position;
   modport source(output valid, mode, entry_value, read_position, input ready);
   modport sink(input valid, mode, entry_value, read_position, output ready);
endinterface

interface pcgfy_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pcgfy_pkg::VALUE_W-1:0]  read_value;
   logic [pcgfy_pkg::COUNT_W-1:0]  entry_count;
   pcgfy_pkg::status_type          status;
   modport source(output valid, read_value, entry_count, status, input ready);
   modport sink(input valid, read_value, entry_count, status, output ready);
endinterface

interface pcgfy_csr_if;
   logic                            valid;
   logic                            ready;
   pcgfy_pkg::csr_idx_type          index;
   logic [pcgfy_pkg::CSR_DAT_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/pcgfy_div.sv
// Bit-serial remainder unit: 64-bit dividend modulo a narrow divisor.
`default_nettype none
module pcgfy_div #(
   parameter int unsigned DW = 11
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pcgfy_pkg::DRAW_W-1:0]  dividend,
   input  wire logic [DW-1:0]                 divisor,
   output logic                               done,
   output logic [DW-1:0]                      rem
);
   localparam int unsigned NW = pcgfy_pkg::DRAW_W;
   localparam int unsigned CB = $clog2(NW);

   logic [NW-1:0] dvd_ff, dvd_in;
   logic [DW-1:0] div_ff, div_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[NW-1]};
      if (start) begin
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so one subtract suffices.
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[DW-1:0];
         end
         dvd_in = {dvd_ff[NW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CB'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("remainder unit restarted while busy");

endmodule
`default_nettype wire

### design/pcgfy_ctrl.sv
// Sequencing state machine for table commands and the shuffle loop.
`default_nettype none
module pcgfy_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire pcgfy_pkg::mode_type  req_mode,
   input  wire pcgfy_pkg::sts_type   sts,
   output logic                      req_ready,
   output pcgfy_pkg::cmd_type        cmd
);
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_RDWAIT  = 4'd1;
   localparam logic [3:0] ST_SEEDMUL = 4'd2;
   localparam logic [3:0] ST_NEXT    = 4'd3;
   localparam logic [3:0] ST_LIMIT   = 4'd4;
   localparam logic [3:0] ST_DRAWHI  = 4'd5;
   localparam logic [3:0] ST_DRAWLO  = 4'd6;
   localparam logic [3:0] ST_CHECK   = 4'd7;
   localparam logic [3:0] ST_MOD     = 4'd8;
   localparam logic [3:0] ST_RDPICK  = 4'd9;
   localparam logic [3:0] ST_WRLAST  = 4'd10;
   localparam logic [3:0] ST_WRPICK  = 4'd11;
   localparam logic [3:0] ST_DONE    = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       accept;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      phase_in  = phase_ff;
      req_ready = (state_ff == ST_IDLE) && sts.rsp_free;
      accept    = req_valid && req_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  pcgfy_pkg::MODE_CLEAR: begin
                     cmd.count_clear = 1'b1;
                     cmd.rsp_load    = 1'b1;
                     cmd.rsp_sel     = pcgfy_pkg::RSP_DIRECT;
                  end
                  pcgfy_pkg::MODE_APPEND: begin
                     cmd.append   = 1'b1;
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = pcgfy_pkg::RSP_DIRECT;
                  end
                  pcgfy_pkg::MODE_SHUFFLE: begin
                     cmd.shuffle_start = 1'b1;
                     phase_in          = pcgfy_pkg::MUL_LOLO;
                     state_in          = ST_SEEDMUL;
                  end
                  default: begin
                     cmd.read_pos = 1'b1;
                     state_in     = ST_RDWAIT;
                  end
               endcase
            end
         end
         ST_RDWAIT: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = pcgfy_pkg::RSP_READ;
            state_in     = ST_IDLE;
         end
         ST_SEEDMUL, ST_DRAWHI, ST_DRAWLO: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = phase_ff;
            cmd.cap_hi    = (state_ff == ST_DRAWHI) && (phase_ff == pcgfy_pkg::MUL_LOLO);
            cmd.cap_lo    = (state_ff == ST_DRAWLO) && (phase_ff == pcgfy_pkg::MUL_LOLO);
            phase_in      = phase_ff + 1'b1;
            if (phase_ff == pcgfy_pkg::MUL_SUM) begin
               case (state_ff)
                  ST_SEEDMUL: state_in = ST_NEXT;
                  ST_DRAWHI:  state_in = ST_DRAWLO;
                  default:    state_in = ST_CHECK;
               endcase
            end
         end
         ST_NEXT: begin
            if (sts.short_top) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_limit = 1'b1;
               state_in      = ST_LIMIT;
            end
         end
         ST_LIMIT: begin
            if (sts.div_done) begin
               cmd.limit_load = 1'b1;
               phase_in       = pcgfy_pkg::MUL_LOLO;
               state_in       = ST_DRAWHI;
            end
         end
         ST_CHECK: begin
            if (sts.draw_low) begin
               phase_in = pcgfy_pkg::MUL_LOLO;
               state_in = ST_DRAWHI;
            end else begin
               cmd.div_draw = 1'b1;
               state_in     = ST_MOD;
            end
         end
         ST_MOD: begin
            if (sts.div_done) begin
               cmd.pick_load = 1'b1;
               cmd.rd_last   = 1'b1;
               state_in      = ST_RDPICK;
            end
         end
         ST_RDPICK: begin
            cmd.tmp_load = 1'b1;
            cmd.rd_pick  = 1'b1;
            state_in     = ST_WRLAST;
         end
         ST_WRLAST: begin
            cmd.wr_last = 1'b1;
            state_in    = ST_WRPICK;
         end
         ST_WRPICK: begin
            cmd.wr_pick = 1'b1;
            cmd.top_dec = 1'b1;
            state_in    = ST_NEXT;
         end
         ST_DONE: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = pcgfy_pkg::RSP_SHUFFLE;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= pcgfy_pkg::MUL_LOLO;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule
`default_nettype wire

### design/pcgfy_dp.sv
// Datapath: entry memory, fill count, generator, draw registers and output register.
`default_nettype none
module pcgfy_dp #(
   parameter int unsigned MAX_ENTRIES = pcgfy_pkg::MAX_ENTRIES_DEF,
   parameter int unsigned ENTRY_WIDTH = pcgfy_pkg::ENTRY_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pcgfy_pkg::cmd_type                cmd,
   output pcgfy_pkg::sts_type                     sts,
   input  wire logic [pcgfy_pkg::VALUE_W-1:0]     req_entry_value,
   input  wire logic [pcgfy_pkg::POS_W-1:0]       req_read_position,
   input  wire logic                              csr_write,
   input  wire pcgfy_pkg::csr_idx_type            csr_index,
   input  wire logic [pcgfy_pkg::CSR_DAT_W-1:0]   csr_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [pcgfy_pkg::VALUE_W-1:0]          rsp_read_value,
   output logic [pcgfy_pkg::COUNT_W-1:0]          rsp_entry_count,
   output pcgfy_pkg::status_type                  rsp_status
);
   localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned PW = (CW > pcgfy_pkg::POS_W) ? CW : pcgfy_pkg::POS_W;

   logic [ENTRY_WIDTH-1:0] mem [MAX_ENTRIES];

   logic [CW-1:0]   count_ff, count_in;
   logic [63:0]     gen_ff, gen_in;
   logic [63:0]     inc_ff, inc_in;
   logic [63:0]     seed_ff;
   logic [62:0]     stream_ff;
   logic [63:0]     prod_ff;
   logic [63:0]     p0_ff;
   logic [31:0]     p1_ff;
   logic [31:0]     hi_ff;
   logic [31:0]     lo_ff;
   logic [CW-1:0]   top_ff;
   logic [CW-1:0]   limit_ff;
   logic [AW-1:0]   pick_ff;
   logic [ENTRY_WIDTH-1:0] rdata_ff;
   logic [ENTRY_WIDTH-1:0] tmp_ff;
   logic            beyond_ff;
   logic            rsp_valid_ff;
   logic [pcgfy_pkg::VALUE_W-1:0] rsp_value_ff;
   logic [pcgfy_pkg::COUNT_W-1:0] rsp_count_ff;
   pcgfy_pkg::status_type         rsp_status_ff;

   logic            full;
   logic [CW-1:0]   top_m1;
   logic [AW-1:0]   last_addr;
   logic [PW-1:0]   pos_ext;
   logic [PW-1:0]   cnt_ext;
   logic [31:0]     mul_a, mul_b;
   logic [63:0]     mul_p;
   logic [31:0]     gen_word;
   logic [AW-1:0]   rd_addr;
   logic            rd_en;
   logic [AW-1:0]   wr_addr;
   logic [ENTRY_WIDTH-1:0] wr_data;
   logic            wr_en;
   logic            div_start;
   logic [63:0]     div_dividend;
   logic            div_done;
   logic [CW-1:0]   div_rem;
   logic [63:0]     rd_ext;
   logic [63:0]     draw;

   assign full      = (count_ff == CW'(MAX_ENTRIES));
   assign top_m1    = top_ff - 1'b1;
   assign last_addr = top_m1[AW-1:0];
   assign pos_ext   = PW'(req_read_position);
   assign cnt_ext   = PW'(count_ff);
   assign gen_word  = pcgfy_pkg::pcg_output(gen_ff);
   assign draw      = {hi_ff, lo_ff};
   assign rd_ext    = 64'(rdata_ff);

   // Fill count and generator state.
   always_comb begin
      count_in = count_ff;
      gen_in   = gen_ff;
      inc_in   = inc_ff;
      if (cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.append && !full) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.shuffle_start) begin
         // The first step from a zero state leaves just the increment.
         inc_in = {stream_ff, 1'b1};
         gen_in = {stream_ff, 1'b1} + seed_ff;
      end else if (cmd.mul_en && (cmd.mul_phase == pcgfy_pkg::MUL_SUM)) begin
         gen_in = p0_ff + {p1_ff + prod_ff[31:0], 32'd0} + inc_ff;
      end
   end

   // One shared 32x32 multiplier for the partial products of a step.
   always_comb begin
      case (cmd.mul_phase)
         pcgfy_pkg::MUL_LOLO: begin
            mul_a = gen_ff[31:0];
            mul_b = pcgfy_pkg::PCG_MULT_LO;
         end
         pcgfy_pkg::MUL_LOHI: begin
            mul_a = gen_ff[31:0];
            mul_b = pcgfy_pkg::PCG_MULT_HI;
         end
         default: begin
            mul_a = gen_ff[63:32];
            mul_b = pcgfy_pkg::PCG_MULT_LO;
         end
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   // Memory port selection.
   always_comb begin
      rd_en   = cmd.read_pos || cmd.rd_last || cmd.rd_pick;
      rd_addr = pick_ff;
      if (cmd.read_pos) begin
         rd_addr = pos_ext[AW-1:0];
      end else if (cmd.rd_last) begin
         rd_addr = last_addr;
      end
      wr_en   = (cmd.append && !full) || cmd.wr_last || cmd.wr_pick;
      wr_addr = pick_ff;
      wr_data = tmp_ff;
      if (cmd.append) begin
         wr_addr = count_ff[AW-1:0];
         wr_data = ENTRY_WIDTH'(req_entry_value);
      end else if (cmd.wr_last) begin
         wr_addr = last_addr;
         wr_data = rdata_ff;
      end
   end

   assign div_start    = cmd.div_limit || cmd.div_draw;
   assign div_dividend = cmd.div_limit ? (64'd0 - 64'(top_ff)) : draw;

   pcgfy_div #(
      .DW(CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (top_ff),
      .done     (div_done),
      .rem      (div_rem)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         gen_ff       <= '0;
         inc_ff       <= 64'd1;
         seed_ff      <= '0;
         stream_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         gen_ff   <= gen_in;
         inc_ff   <= inc_in;
         if (csr_write) begin
            case (csr_index)
               pcgfy_pkg::CSR_SEED:   seed_ff   <= csr_data;
               pcgfy_pkg::CSR_STREAM: stream_ff <= csr_data[62:0];
               default: ;
            endcase
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
         if (cmd.mul_phase == pcgfy_pkg::MUL_LOHI) begin
            p0_ff <= prod_ff;
         end
         if (cmd.mul_phase == pcgfy_pkg::MUL_HILO) begin
            p1_ff <= prod_ff[31:0];
         end
      end
      if (cmd.cap_hi) begin
         hi_ff <= gen_word;
      end
      if (cmd.cap_lo) begin
         lo_ff <= gen_word;
      end
      if (cmd.shuffle_start) begin
         top_ff <= count_ff;
      end else if (cmd.top_dec) begin
         top_ff <= top_m1;
      end
      if (cmd.limit_load) begin
         limit_ff <= div_rem;
      end
      if (cmd.pick_load) begin
         pick_ff <= div_rem[AW-1:0];
      end
      if (cmd.tmp_load) begin
         tmp_ff <= rdata_ff;
      end
      if (cmd.read_pos) begin
         beyond_ff <= (pos_ext >= cnt_ext);
      end
      if (cmd.rsp_load) begin
         case (cmd.rsp_sel)
            pcgfy_pkg::RSP_DIRECT: begin
               rsp_value_ff  <= '0;
               rsp_count_ff  <= pcgfy_pkg::COUNT_W'(count_in);
               rsp_status_ff <= (cmd.append && full) ? pcgfy_pkg::STATUS_FULL
                                                    : pcgfy_pkg::STATUS_OK;
            end
            pcgfy_pkg::RSP_READ: begin
               rsp_value_ff  <= beyond_ff ? '0 : rd_ext[31:0];
               rsp_count_ff  <= pcgfy_pkg::COUNT_W'(count_ff);
               rsp_status_ff <= beyond_ff ? pcgfy_pkg::STATUS_BEYOND : pcgfy_pkg::STATUS_OK;
            end
            default: begin
               rsp_value_ff  <= '0;
               rsp_count_ff  <= pcgfy_pkg::COUNT_W'(count_ff);
               rsp_status_ff <= pcgfy_pkg::STATUS_OK;
            end
         endcase
      end
   end

   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign sts.short_top = (top_ff < CW'(2));
   assign sts.draw_low  = (draw < 64'(limit_ff));
   assign sts.div_done  = div_done;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES)) else $error("fill count beyond table depth");

   a_pick_below_top: assert property (@(posedge clock) disable iff (reset)
      cmd.pick_load |-> (div_rem < top_ff)) else $error("swap partner not below top");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready)) else $error("response overwritten");

endmodule
`default_nettype wire

### design/pcg32_seeded_fisher_yates_shuffle.sv
// Top level of the shuffle table with a PCG32-seeded Fisher-Yates permutation.
//
// Requests arrive on req_chan, one transaction per command: clear, append, shuffle or read.
// Every request yields exactly one response transaction on rsp_chan, in order.
// Registers shuffle_seed (index 0) and stream_number (index 1) are written on csr_chan,
// which is always ready; write them only while no request is outstanding.
// Clear and append answer in the cycle after they are taken.
// A read passes through the registered read port of the entry memory, then the output register.
// A shuffle of N entries walks the bounds N down to 2 and takes one or more 64-bit draws at each
// bound (almost always one); each bound makes two passes of the bit-serial remainder unit, and
// each generator step runs on one shared multiplier.
// Requests are not taken while a command is at work.
// A response waits in the output register while rsp_chan.ready is low; the next request
// is taken in the cycle that response leaves.
// Synchronous reset empties the table count, sets the generator to state zero and
// increment one, clears both registers, and drops any pending response.
`default_nettype none
module pcg32_seeded_fisher_yates_shuffle #(
   parameter int unsigned MAX_ENTRIES = pcgfy_pkg::MAX_ENTRIES_DEF,
   parameter int unsigned ENTRY_WIDTH = pcgfy_pkg::ENTRY_WIDTH_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   pcgfy_req_if.sink     req_chan,
   pcgfy_rsp_if.source   rsp_chan,
   pcgfy_csr_if.sink     csr_chan
);
   pcgfy_pkg::cmd_type cmd;
   pcgfy_pkg::sts_type sts;
   logic               req_ready;

   // The register port never stalls; writes land in the datapath at once.
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = req_ready;

   // The controller sequences every command, the datapath holds the table, generator and response state.
   pcgfy_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .sts       (sts),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   pcgfy_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_entry_value   (req_chan.entry_value),
      .req_read_position (req_chan.read_position),
      .csr_write         (csr_chan.valid),
      .csr_index         (csr_chan.index),
      .csr_data          (csr_chan.data),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_read_value    (rsp_chan.read_value),
      .rsp_entry_count   (rsp_chan.entry_count),
      .rsp_status        (rsp_chan.status)
   );

endmodule
`default_nettype wire

### bench/tb_pcg32_seeded_fisher_yates_shuffle.sv
// Self-checking testbench of the PCG32-seeded Fisher-Yates shuffle table.
`default_nettype none
module tb_pcg32_seeded_fisher_yates_shuffle;

   // One response transaction as the table should produce it.
   typedef struct {
      logic [pcgfy_pkg::VALUE_W-1:0] read_value;
      logic [pcgfy_pkg::COUNT_W-1:0] entry_count;
      pcgfy_pkg::status_type         status;
   } table_answer_type;

   localparam int unsigned TABLE_DEPTH = pcgfy_pkg::MAX_ENTRIES_DEF;
   localparam logic [63:0] PCG_MULTIPLIER = {pcgfy_pkg::PCG_MULT_HI, pcgfy_pkg::PCG_MULT_LO};

   logic clock;
   logic reset;

   pcgfy_req_if req_chan ();
   pcgfy_rsp_if rsp_chan ();
   pcgfy_csr_if csr_chan ();

   pcg32_seeded_fisher_yates_shuffle i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   // The bench keeps its own copy of the table, the generator and both registers.
   logic [pcgfy_pkg::VALUE_W-1:0]  shadow_table [TABLE_DEPTH];
   int unsigned                    shadow_count;
   logic [63:0]                    shadow_gen_state;
   logic [63:0]                    shadow_gen_inc;
   logic [pcgfy_pkg::SEED_W-1:0]   shadow_seed;
   logic [pcgfy_pkg::STREAM_W-1:0] shadow_stream;

   // Answers still owed by the block, oldest at the front.
   table_answer_type owed_answers [$];

   int unsigned mismatch_count = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;
   // A test sets this to ask the receiver for a long hold-off; the receiver takes it over.
   int unsigned hold_off_request = 0;

   // The clock runs with a period of 12 time units.
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The generator: one XSH-RR output taken from the old state, then an LCG advance.
   function automatic logic [31:0] next_word();
      logic [63:0] old;
      logic [63:0] folded;
      logic [31:0] mixed;
      logic [4:0]  rot;
      logic [63:0] twice;
      old = shadow_gen_state;
      shadow_gen_state = old * PCG_MULTIPLIER + shadow_gen_inc;
      folded = old ^ (old >> 18);
      mixed = folded[58:27];
      rot = old[63:59];
      twice = {mixed, mixed} >> rot;
      return twice[31:0];
   endfunction

   // Unbiased pick below bound by rejection of the low draws.
   function automatic int unsigned bounded_pick(int unsigned bound);
      logic [63:0] wide_bound;
      logic [63:0] reject_below;
      logic [63:0] draw;
      wide_bound = 64'(bound);
      reject_below = (64'd0 - wide_bound) % wide_bound;
      forever begin
         draw[63:32] = next_word();
         draw[31:0]  = next_word();
         if (draw >= reject_below) return int'(draw % wide_bound);
      end
   endfunction

   // Reseed the generator and permute the held entries from the top down.
   function automatic void permute_table();
      int unsigned top;
      int unsigned pick;
      logic [pcgfy_pkg::VALUE_W-1:0] swap_word;
      shadow_gen_inc = {shadow_stream, 1'b1};
      shadow_gen_state = 64'd0;
      void'(next_word());
      shadow_gen_state = shadow_gen_state + shadow_seed;
      void'(next_word());
      for (top = shadow_count; top > 1; top--) begin
         pick = bounded_pick(top);
         swap_word = shadow_table[top-1];
         shadow_table[top-1] = shadow_table[pick];
         shadow_table[pick] = swap_word;
      end
   endfunction

   // Apply one accepted request to the shadow state and return the answer it owes.
   function automatic table_answer_type table_answer(pcgfy_pkg::mode_type mode,
                                                     logic [pcgfy_pkg::VALUE_W-1:0] value,
                                                     logic [pcgfy_pkg::POS_W-1:0] pos);
      table_answer_type ans;
      ans.read_value = '0;
      ans.status = pcgfy_pkg::STATUS_OK;
      case (mode)
         pcgfy_pkg::MODE_CLEAR: shadow_count = 0;
         pcgfy_pkg::MODE_APPEND: begin
            if (shadow_count >= TABLE_DEPTH) begin
               ans.status = pcgfy_pkg::STATUS_FULL;
            end else begin
               shadow_table[shadow_count] = value;
               shadow_count++;
            end
         end
         pcgfy_pkg::MODE_SHUFFLE: permute_table();
         default: begin
            if (int'(pos) >= shadow_count) ans.status = pcgfy_pkg::STATUS_BEYOND;
            else ans.read_value = shadow_table[pos];
         end
      endcase
      ans.entry_count = pcgfy_pkg::COUNT_W'(shadow_count);
      return ans;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got 0x%0h, wanted 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Offer one request, idling first at the current rate, and wait until it is taken.
   task automatic send_item(pcgfy_pkg::mode_type mode, logic [pcgfy_pkg::VALUE_W-1:0] value,
                            logic [pcgfy_pkg::POS_W-1:0] pos);
      table_answer_type ans;
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid         <= 1'b1;
      req_chan.mode          <= mode;
      req_chan.entry_value   <= value;
      req_chan.read_position <= pos;
      do @(posedge clock); while (!req_chan.ready);
      ans = table_answer(mode, value, pos);
      owed_answers.push_back(ans);
   endtask

   // Lower valid and wait for every owed answer, then a few quiet cycles.
   task automatic drain_answers();
      req_chan.valid <= 1'b0;
      while (owed_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register writes happen only while the table is idle.
   task automatic write_register(pcgfy_pkg::csr_idx_type index,
                                 logic [pcgfy_pkg::CSR_DAT_W-1:0] data);
      drain_answers();
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      if (index == pcgfy_pkg::CSR_SEED) shadow_seed = data;
      else shadow_stream = data[pcgfy_pkg::STREAM_W-1:0];
   endtask

   // The receiver: honours a requested hold-off first, otherwise idles at its rate.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request != 0) begin
            hold_left = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Each response transaction is compared with the oldest owed answer.
   always @(posedge clock) begin
      table_answer_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (owed_answers.size() == 0) begin
            report_mismatch("response with none owed", rsp_chan.entry_count, 0);
         end else begin
            want = owed_answers.pop_front();
            if (rsp_chan.read_value !== want.read_value)
               report_mismatch("read_value", rsp_chan.read_value, want.read_value);
            if (rsp_chan.entry_count !== want.entry_count)
               report_mismatch("entry_count", rsp_chan.entry_count, want.entry_count);
            if (rsp_chan.status !== want.status)
               report_mismatch("status", rsp_chan.status, want.status);
         end
      end
   end

   // Reads and shuffles on an empty table, right after reset.
   task automatic test_empty_table();
      send_item(pcgfy_pkg::MODE_READ, '0, '0);
      send_item(pcgfy_pkg::MODE_READ, '0, '1);
      send_item(pcgfy_pkg::MODE_SHUFFLE, '0, '0);
      send_item(pcgfy_pkg::MODE_CLEAR, '1, '1);
   endtask

   // Extreme words go in and come back; reads at and past the count are flagged.
   task automatic test_append_and_read();
      send_item(pcgfy_pkg::MODE_APPEND, '0, '1);
      send_item(pcgfy_pkg::MODE_SHUFFLE, '0, '0);  // a single entry only reseeds the generator
      send_item(pcgfy_pkg::MODE_APPEND, '1, '0);
      send_item(pcgfy_pkg::MODE_APPEND, 32'hA5A5_5A5A, '0);
      send_item(pcgfy_pkg::MODE_READ, '0, 10'd0);
      send_item(pcgfy_pkg::MODE_READ, '0, 10'd1);
      send_item(pcgfy_pkg::MODE_READ, '0, 10'd2);
      send_item(pcgfy_pkg::MODE_READ, '0, 10'd3);
      send_item(pcgfy_pkg::MODE_READ, '1, '1);
   endtask

   // A small shuffle, then clear keeps contents hidden until appends overwrite them.
   task automatic test_small_shuffle();
      send_item(pcgfy_pkg::MODE_APPEND, 32'h0000_0004, '0);
      send_item(pcgfy_pkg::MODE_SHUFFLE, '0, '0);
      for (int p = 0; p < 4; p++)
         send_item(pcgfy_pkg::MODE_READ, '0, pcgfy_pkg::POS_W'(p));
      send_item(pcgfy_pkg::MODE_CLEAR, '0, '0);
      send_item(pcgfy_pkg::MODE_READ, '0, 10'd0);
      send_item(pcgfy_pkg::MODE_APPEND, 32'h1234_5678, '0);
      send_item(pcgfy_pkg::MODE_READ, '0, 10'd0);
   endtask

   // Fill the table to the brim, try to overflow it, and shuffle the lot once.
   task automatic test_full_table();
      send_item(pcgfy_pkg::MODE_CLEAR, '0, '0);
      for (int n = 0; n < TABLE_DEPTH; n++)
         send_item(pcgfy_pkg::MODE_APPEND, $urandom, pcgfy_pkg::POS_W'($urandom));
      send_item(pcgfy_pkg::MODE_APPEND, '1, '0);
      send_item(pcgfy_pkg::MODE_APPEND, $urandom, '0);
      send_item(pcgfy_pkg::MODE_READ, '0, '1);
      send_item(pcgfy_pkg::MODE_SHUFFLE, '0, '0);
      send_item(pcgfy_pkg::MODE_READ, '0, '0);
      send_item(pcgfy_pkg::MODE_READ, '0, '1);
      for (int n = 0; n < 6; n++)
         send_item(pcgfy_pkg::MODE_READ, '0, pcgfy_pkg::POS_W'($urandom));
      send_item(pcgfy_pkg::MODE_CLEAR, '0, '0);
   endtask

   // The receiver stalls for a long stretch while the sender keeps offering requests.
   task automatic test_backpressure();
      hold_off_request = 400;
      for (int n = 0; n < 24; n++) begin
         if (n % 3 == 2)
            send_item(pcgfy_pkg::MODE_READ, '0, pcgfy_pkg::POS_W'($urandom_range(15)));
         else send_item(pcgfy_pkg::MODE_APPEND, $urandom, '0);
      end
      send_item(pcgfy_pkg::MODE_SHUFFLE, '0, '0);
      send_item(pcgfy_pkg::MODE_READ, '0, 10'd0);
   endtask

   // Mostly well-formed fill, shuffle and read-back sequences, with some noise between.
   task automatic test_random_sequences(int unsigned item_budget);
      int unsigned start;
      int unsigned fill;
      start = 0;
      while (start < item_budget) begin
         if ($urandom_range(99) < 80) begin
            fill = $urandom_range(1, 12);
            send_item(pcgfy_pkg::MODE_CLEAR, $urandom, pcgfy_pkg::POS_W'($urandom));
            for (int n = 0; n < fill; n++)
               send_item(pcgfy_pkg::MODE_APPEND, $urandom, pcgfy_pkg::POS_W'($urandom));
            if ($urandom_range(1))
               send_item(pcgfy_pkg::MODE_READ, '0, pcgfy_pkg::POS_W'($urandom_range(fill - 1)));
            send_item(pcgfy_pkg::MODE_SHUFFLE, $urandom, pcgfy_pkg::POS_W'($urandom));
            for (int p = 0; p < fill; p++)
               send_item(pcgfy_pkg::MODE_READ, $urandom, pcgfy_pkg::POS_W'(p));
            start += 3 + 2 * fill;
         end else begin
            for (int n = 0; n < 4; n++) begin
               // Noise shuffles are kept rare, since a shuffle is the longest command.
               pcgfy_pkg::mode_type m;
               m = pcgfy_pkg::mode_type'($urandom_range(3));
               if (m == pcgfy_pkg::MODE_SHUFFLE && $urandom_range(3) != 0)
                  m = pcgfy_pkg::MODE_READ;
               send_item(m, $urandom, pcgfy_pkg::POS_W'($urandom));
            end
            start += 4;
         end
      end
   endtask

   initial begin
      shadow_count = 0;
      shadow_gen_state = 64'd0;
      shadow_gen_inc = 64'd1;
      shadow_seed = '0;
      shadow_stream = '0;
      foreach (shadow_table[i]) shadow_table[i] = '0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.mode <= pcgfy_pkg::MODE_CLEAR;
      req_chan.entry_value <= '0;
      req_chan.read_position <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= pcgfy_pkg::CSR_SEED;
      csr_chan.data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with both registers at zero first.
      send_idle_pct = 37;
      recv_idle_pct = 50;
      write_register(pcgfy_pkg::CSR_SEED, '0);
      write_register(pcgfy_pkg::CSR_STREAM, '0);
      test_empty_table();
      test_append_and_read();
      write_register(pcgfy_pkg::CSR_SEED, '1);
      write_register(pcgfy_pkg::CSR_STREAM, {1'b0, {pcgfy_pkg::STREAM_W{1'b1}}});
      test_small_shuffle();
      test_backpressure();

      // First random phase: sender idles less than the receiver.
      write_register(pcgfy_pkg::CSR_SEED, {$urandom, $urandom});
      write_register(pcgfy_pkg::CSR_STREAM, {$urandom, $urandom});
      test_random_sequences(170);

      // Second phase: the other way round, with the full table here.
      drain_answers();
      send_idle_pct = 50;
      recv_idle_pct = 37;
      write_register(pcgfy_pkg::CSR_SEED, {$urandom, $urandom});
      write_register(pcgfy_pkg::CSR_STREAM, '0);
      test_full_table();
      test_random_sequences(170);

      // Third phase: nobody idles.
      drain_answers();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(pcgfy_pkg::CSR_SEED, 64'd1);
      write_register(pcgfy_pkg::CSR_STREAM, {$urandom, $urandom});
      test_random_sequences(170);

      drain_answers();
      repeat (20) @(posedge clock);
      if (owed_answers.size() != 0)
         report_mismatch("answers never delivered", owed_answers.size(), 0);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Guard against a hang; the slowest correct run is far shorter than this.
   initial begin
      #(12 * 4000000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire
